@@ hdl/pdrs_pkg.sv @@
package pdrs_pkg;

  localparam int PREFIX_LEN_DEF = 7;
  localparam int MAX_DIGITS_DEF = 16;

  localparam int CFG_DATA_W  = 56;
  localparam int CFG_INDEX_W = 1;
  localparam int MIN_W       = 5;
  localparam int LEN_W       = 5;
  localparam int BCD_OUT_W   = 64;
  localparam int CNT_W       = 32;
  localparam int IN_DATA_W   = 8;
  // run_length + digits_bcd + found_total + short_total, padded to whole bytes
  localparam int OUT_FIELDS_W = LEN_W + BCD_OUT_W + 2 * CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_DATA_W-1:0] PREFIX_RESET = 56'h23_2323_494D_4549; // "###IMEI"
  localparam logic [MIN_W-1:0]      MIN_RESET    = 5'd15;

  localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN    = 1'b1;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

endpackage

@@ hdl/prefix_digit_run_scanner_core.sv @@
// Prefix / digit-run scanner.
// Input stream: one byte per transfer on in_tdata (in_tvalid/in_tready).
// The last PREFIX_LEN bytes form a sliding window; when it matches the
// configured prefix the window is emptied and ASCII digits are collected.
// A run ends on a non-digit byte or when MAX_DIGITS digits are held; each
// ended run gives one transfer on the out_ channel: out_tuser is the status
// (0 found, 1 too short), out_tdata holds length, BCD digits and the two
// wrapping run counters.
// Throughput: one byte per cycle unless the output stalls. Latency: the result
// is on out_tvalid the cycle after the byte that ends the run; all work is one
// combinational step between the scanner state and the output register.
// The output register is a single stage: while it holds an untaken result
// in_tready follows out_tready, so a stalled receiver holds off the input.
// Configuration (cfg_wr_en/cfg_index/cfg_data) is written while idle; the
// user must keep to this, the block does not enforce it. Reset (rst_n low,
// synchronous) clears the window, run state, counters and the output valid
// flag, and loads the default prefix "###IMEI" and a minimum run of 15 digits.
module prefix_digit_run_scanner_core #(
  parameter int PREFIX_LEN = pdrs_pkg::PREFIX_LEN_DEF,
  parameter int MAX_DIGITS = pdrs_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pdrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pdrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pdrs_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] byte_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [4:0] run_length, [68:5] digits_bcd, [100:69] found_total,
  // [132:101] short_total, [135:133] zero
  output logic [pdrs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser   // [0] run_status
);
  import pdrs_pkg::*;

  localparam int WIN_W  = 8 * PREFIX_LEN;
  localparam int FILL_W = $clog2(PREFIX_LEN + 1);
  localparam int TOT_W  = $clog2(MAX_DIGITS + 1);
  localparam int BCD_W  = 4 * MAX_DIGITS;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PREFIX_LEN);
  localparam logic [TOT_W-1:0]  TOT_MAX   = TOT_W'(MAX_DIGITS);

  logic [CFG_DATA_W-1:0] prefix_r;
  logic [MIN_W-1:0]      min_digits_r;

  logic [WIN_W-1:0]  win_r,  win_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              coll_r, coll_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [CNT_W-1:0]  found_r, found_nxt;
  logic [CNT_W-1:0]  short_r, short_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [BCD_W-1:0]  out_bcd_r, out_bcd_nxt;

  logic                 acc;
  logic                 load;
  logic [7:0]           c;
  logic                 is_digit;
  logic [BCD_W-1:0]     bcd_dig;
  logic [TOT_W-1:0]     total_inc;
  logic [TOT_W-1:0]     end_len;
  logic                 found;
  logic [BCD_OUT_W+7:0] pat_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign is_digit  = (c >= CH_0) && (c <= CH_9);
  assign total_inc = total_r + 1'b1;
  assign pat_ext   = (BCD_OUT_W + 8)'(prefix_r);

  always_comb begin
    bcd_dig = bcd_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (total_r == TOT_W'(i)) begin
        bcd_dig[4*i +: 4] = c[3:0];
      end
    end
  end

  always_comb begin
    win_nxt     = win_r;
    fill_nxt    = fill_r;
    coll_nxt    = coll_r;
    total_nxt   = total_r;
    bcd_nxt     = bcd_r;
    found_nxt   = found_r;
    short_nxt   = short_r;
    load        = 1'b0;
    end_len     = total_r;
    out_bcd_nxt = out_bcd_r;
    if (acc) begin
      if (coll_r && is_digit) begin
        bcd_nxt = bcd_dig;
        if (total_inc == TOT_MAX) begin
          load        = 1'b1;
          end_len     = total_inc;
          out_bcd_nxt = bcd_dig;
          coll_nxt    = 1'b0;
          total_nxt   = '0;
        end else begin
          total_nxt = total_inc;
        end
      end else begin
        if (coll_r) begin
          load        = 1'b1;
          end_len     = total_r;
          out_bcd_nxt = bcd_r;
          coll_nxt    = 1'b0;
          total_nxt   = '0;
        end
        win_nxt  = WIN_W'({win_r, c});
        fill_nxt = (fill_r == FILL_FULL) ? FILL_FULL : fill_r + 1'b1;
        if (fill_nxt == FILL_FULL && win_nxt == pat_ext[WIN_W-1:0]) begin
          coll_nxt  = 1'b1;
          total_nxt = '0;
          fill_nxt  = '0;
          bcd_nxt   = '0;
        end
      end
    end
    found = LEN_W'(end_len) >= min_digits_r;
    if (load) begin
      if (found) begin
        found_nxt = found_r + 1'b1;
      end else begin
        short_nxt = short_r + 1'b1;
      end
    end
    out_status_nxt = load ? (found ? STATUS_FOUND : STATUS_SHORT) : out_status_r;
    out_len_nxt    = load ? LEN_W'(end_len) : out_len_r;
    out_valid_nxt  = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r     <= PREFIX_RESET;
      min_digits_r <= MIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PREFIX: prefix_r     <= cfg_data;
        CFG_MIN:    min_digits_r <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      fill_r      <= '0;
      coll_r      <= 1'b0;
      total_r     <= '0;
      bcd_r       <= '0;
      found_r     <= '0;
      short_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      coll_r      <= coll_nxt;
      total_r     <= total_nxt;
      bcd_r       <= bcd_nxt;
      found_r     <= found_nxt;
      short_r     <= short_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_bcd_r    <= out_bcd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'({short_r, found_r, BCD_OUT_W'(out_bcd_r), out_len_r});

  // counters shown with a result are those after it was counted
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_len_r <= LEN_W'(MAX_DIGITS))
    else $error("run length above maximum");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_status_r == STATUS_FOUND) == (out_len_r >= min_digits_r)))
    else $error("run status disagrees with length");

  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (found_r + short_r) == ($past(found_r) + $past(short_r) + 1'b1))
    else $error("ended run not counted exactly once");

  a_idle_total: assert property (@(posedge clk) disable iff (!rst_n)
    !coll_r |-> total_r == '0)
    else $error("digit count held outside a run");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill overrun");

endmodule
